@@ hdl/rrop_pkg.sv @@
// Shared types, register codes and pipeline constants for the rectangle raster-op engine.
// Depends on nothing; imported by rect_raster_op_pixel_engine.
package rrop_pkg;

  // Default coordinate width of the pixel stream.
  localparam int COORD_BITS_DEF = 12;

  // Configuration port and register widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_W      = 14;
  localparam int ALPHA_W    = 8;
  localparam int MODE_W     = 2;
  localparam int PIX_W      = 32;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int PROD_W     = 2 * CHAN_W;

  // Signed width for coordinate sums (edge plus extent never overflows it).
  localparam int CALC_W = REG_W + 2;

  // Gradient quotient: row offset times 255 over (height - 1), eight quotient bits.
  localparam int DIFF_W    = REG_W - 1;
  localparam int NUM_W     = DIFF_W + CHAN_W;
  localparam int QUO_W     = CHAN_W;
  localparam int DIV_STEPS = QUO_W;

  // Pipeline stage numbering.
  localparam int ST_FRONT   = 0;
  localparam int ST_PROD    = 1;
  localparam int DIV_FIRST  = 2;
  localparam int ST_GMUL    = DIV_FIRST + DIV_STEPS;
  localparam int ST_GQUO    = ST_GMUL + 1;
  localparam int ST_OUT     = ST_GQUO + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd255;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT,
    REG_RECT_TOP,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_FIRST_COLOUR,
    REG_SECOND_COLOUR,
    REG_BLEND_ALPHA,
    REG_DRAW_MODE
  } cfg_reg_t;

  // Drawing operations.
  typedef enum logic [MODE_W-1:0] {
    MODE_FILL,
    MODE_OUTLINE,
    MODE_GRADIENT,
    MODE_BLEND
  } draw_mode_t;

  // Payload of one quotient stage.
  typedef struct packed {
    logic              wr;
    logic              grad_sel;
    logic [PIX_W-1:0]  base;
    logic [NUM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

  // Payload of the gradient product stage.
  typedef struct packed {
    logic                             wr;
    logic                             grad_sel;
    logic [PIX_W-1:0]                 base;
    logic [NUM_CHAN-1:0]              neg;
    logic [NUM_CHAN-1:0][PROD_W-1:0]  prod;
  } gmul_stage_t;

  // Payload of the gradient quotient stage.
  typedef struct packed {
    logic                             wr;
    logic                             grad_sel;
    logic [PIX_W-1:0]                 base;
    logic [NUM_CHAN-1:0]              neg;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  step;
  } gquo_stage_t;

endpackage

@@ hdl/rect_raster_op_pixel_engine.sv @@
// Requests pass through 13 register stages; the accepting edge loads the first.
// Throughput: one pixel per cycle while out_ready is high; the eight one-bit stages of
// the gradient quotient set the depth, and every stage passes its item on as soon as
// the next one is free. Each stage stalls only when it and all stages after it hold
// items and out_ready is low.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register defaults:
// all zero except blend_alpha, which comes up as 255.
module rect_raster_op_pixel_engine
  import rrop_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Pixel requests
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_BITS-1:0]  in_pixel_col,
  input  logic [COORD_BITS-1:0]  in_pixel_row,
  input  logic [PIX_W-1:0]       in_dest_pixel,
  // Results
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIX_W-1:0]       out_pixel_out,
  output logic                   out_write_flag
);

  // Configuration registers.
  logic signed [REG_W-1:0] rect_left_r;
  logic signed [REG_W-1:0] rect_top_r;
  logic signed [REG_W-1:0] rect_width_r;
  logic signed [REG_W-1:0] rect_height_r;
  logic [PIX_W-1:0]        first_colour_r;
  logic [PIX_W-1:0]        second_colour_r;
  logic [ALPHA_W-1:0]      blend_alpha_r;
  draw_mode_t              draw_mode_r;

  // Register writes; all eight indexes are defined.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r     <= '0;
      rect_top_r      <= '0;
      rect_width_r    <= '0;
      rect_height_r   <= '0;
      first_colour_r  <= '0;
      second_colour_r <= '0;
      blend_alpha_r   <= ALPHA_RESET;
      draw_mode_r     <= MODE_FILL;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_RECT_LEFT:     rect_left_r     <= cfg_data[REG_W-1:0];
        REG_RECT_TOP:      rect_top_r      <= cfg_data[REG_W-1:0];
        REG_RECT_WIDTH:    rect_width_r    <= cfg_data[REG_W-1:0];
        REG_RECT_HEIGHT:   rect_height_r   <= cfg_data[REG_W-1:0];
        REG_FIRST_COLOUR:  first_colour_r  <= cfg_data[PIX_W-1:0];
        REG_SECOND_COLOUR: second_colour_r <= cfg_data[PIX_W-1:0];
        REG_BLEND_ALPHA:   blend_alpha_r   <= cfg_data[ALPHA_W-1:0];
        REG_DRAW_MODE:     draw_mode_r     <= draw_mode_t'(cfg_data[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain. A stage moves when it is empty or
  // when the stage after it moves.
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES:0]   stage_en;

  always_comb begin
    stage_en[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  assign valid_nxt = {valid_r[NUM_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid_r[k] <= valid_nxt[k];
        end
      end
    end
  end

  assign in_ready  = stage_en[ST_FRONT];
  assign out_valid = valid_r[ST_OUT];

  // Rectangle edges in a common signed width.
  logic signed [CALC_W-1:0] px, py, rx, ry, rw, rh;
  logic signed [CALC_W-1:0] x_end, y_end, x_last, y_last, row_off;
  logic                     x_in, y_in, row_hit, col_hit, wr_front;

  always_comb begin
    px      = signed'(CALC_W'(in_pixel_col));
    py      = signed'(CALC_W'(in_pixel_row));
    rx      = CALC_W'(rect_left_r);
    ry      = CALC_W'(rect_top_r);
    rw      = CALC_W'(rect_width_r);
    rh      = CALC_W'(rect_height_r);
    x_end   = rx + rw;
    y_end   = ry + rh;
    x_last  = x_end - CALC_W'(1);
    y_last  = y_end - CALC_W'(1);
    row_off = py - ry;
    x_in    = (rect_width_r > 0) && (px >= rx) && (px < x_end);
    y_in    = (rect_height_r > 0) && (py >= ry) && (py < y_end);
    row_hit = ((py == ry) || (py == y_last)) && x_in;
    col_hit = ((px == rx) || (px == x_last)) && y_in;
    case (draw_mode_r)
      MODE_OUTLINE: wr_front = row_hit || col_hit;
      default:      wr_front = x_in && y_in;
    endcase
  end

  // Front stage: hit decision and row offset inside the rectangle.
  logic              s0_wr_r;
  logic [DIFF_W-1:0] s0_diff_r;
  logic [PIX_W-1:0]  s0_dst_r;

  always_ff @(posedge clk) begin
    if (stage_en[ST_FRONT]) begin
      s0_wr_r   <= wr_front;
      s0_diff_r <= row_off[DIFF_W-1:0];
      s0_dst_r  <= in_dest_pixel;
    end
  end

  // Product stage: dividend for the gradient and the blend products.
  logic [ALPHA_W-1:0]               alpha_inv;
  logic [NUM_CHAN-1:0][PROD_W-1:0]  bd_nxt, bs_nxt;
  logic [NUM_W-1:0]                 num_nxt;

  assign alpha_inv = CHAN_MAX - blend_alpha_r;
  assign num_nxt   = (NUM_W'(s0_diff_r) << CHAN_W) - NUM_W'(s0_diff_r);

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      bd_nxt[c] = PROD_W'(s0_dst_r[c*CHAN_W +: CHAN_W]) * PROD_W'(alpha_inv);
      bs_nxt[c] = PROD_W'(first_colour_r[c*CHAN_W +: CHAN_W]) * PROD_W'(blend_alpha_r);
    end
  end

  logic                             s1_wr_r;
  logic [PIX_W-1:0]                 s1_dst_r;
  logic [NUM_W-1:0]                 s1_num_r;
  logic [NUM_CHAN-1:0][PROD_W-1:0]  s1_bd_r, s1_bs_r;

  always_ff @(posedge clk) begin
    if (stage_en[ST_PROD]) begin
      s1_wr_r  <= s0_wr_r;
      s1_dst_r <= s0_dst_r;
      s1_num_r <= num_nxt;
      s1_bd_r  <= bd_nxt;
      s1_bs_r  <= bs_nxt;
    end
  end

  // Resolve fill, outline and blend into a base word; gradient is finished later.
  logic [PROD_W-1:0]                blend_sum;
  logic [NUM_CHAN*CHAN_W-1:0]       blend_rgb;
  logic [PIX_W-1:0]                 res_fixed;
  div_stage_t                       div_head;

  always_comb begin
    blend_sum = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      blend_sum = s1_bd_r[c] + s1_bs_r[c];
      blend_rgb[c*CHAN_W +: CHAN_W] = blend_sum[PROD_W-1:CHAN_W];
    end
    case (draw_mode_r)
      MODE_BLEND: res_fixed = {ALPHA_OPAQUE, blend_rgb};
      default:    res_fixed = first_colour_r;
    endcase
    div_head.wr       = s1_wr_r;
    div_head.grad_sel = s1_wr_r && (draw_mode_r == MODE_GRADIENT);
    div_head.base     = s1_wr_r ? res_fixed : s1_dst_r;
    div_head.rem      = s1_num_r;
    div_head.quo      = '0;
  end

  // Restoring quotient, one bit per stage, most significant bit first.
  logic [DIFF_W-1:0] divisor;
  div_stage_t        div_r [DIV_STEPS];

  assign divisor = rect_height_r[DIFF_W-1:0] - DIFF_W'(1);

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    div_stage_t       cur;
    div_stage_t       div_nxt;
    logic [NUM_W-1:0] dsh;

    if (j == 0) begin : g_head
      assign cur = div_head;
    end else begin : g_tail
      assign cur = div_r[j-1];
    end

    assign dsh = NUM_W'(divisor) << (QUO_W - 1 - j);

    always_comb begin
      div_nxt = cur;
      if (cur.rem >= dsh) begin
        div_nxt.rem = cur.rem - dsh;
        div_nxt.quo[QUO_W-1-j] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[DIV_FIRST+j]) begin
        div_r[j] <= div_nxt;
      end
    end
  end

  // Gradient products: channel difference magnitude times the row weight.
  logic [QUO_W-1:0] grad_t;
  logic [CHAN_W-1:0] ch_top, ch_bot, ch_mag;
  gmul_stage_t      gmul_nxt;
  gmul_stage_t      gmul_r;

  assign grad_t = (rect_height_r > 14'sd1) ? div_r[DIV_STEPS-1].quo : '0;

  always_comb begin
    ch_top = '0;
    ch_bot = '0;
    ch_mag = '0;
    gmul_nxt.wr       = div_r[DIV_STEPS-1].wr;
    gmul_nxt.grad_sel = div_r[DIV_STEPS-1].grad_sel;
    gmul_nxt.base     = div_r[DIV_STEPS-1].base;
    for (int c = 0; c < NUM_CHAN; c++) begin
      ch_top = first_colour_r[c*CHAN_W +: CHAN_W];
      ch_bot = second_colour_r[c*CHAN_W +: CHAN_W];
      gmul_nxt.neg[c] = ch_bot < ch_top;
      ch_mag = gmul_nxt.neg[c] ? (ch_top - ch_bot) : (ch_bot - ch_top);
      gmul_nxt.prod[c] = PROD_W'(ch_mag) * PROD_W'(grad_t);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_GMUL]) begin
      gmul_r <= gmul_nxt;
    end
  end

  // Divide each product by 255: (m + (m >> 8) + 1) >> 8 is exact for every product (at most 65025).
  logic [PROD_W-1:0] q_sum;
  gquo_stage_t       gquo_nxt;
  gquo_stage_t       gquo_r;

  always_comb begin
    q_sum = '0;
    gquo_nxt.wr       = gmul_r.wr;
    gquo_nxt.grad_sel = gmul_r.grad_sel;
    gquo_nxt.base     = gmul_r.base;
    gquo_nxt.neg      = gmul_r.neg;
    for (int c = 0; c < NUM_CHAN; c++) begin
      q_sum = gmul_r.prod[c] + (gmul_r.prod[c] >> CHAN_W) + PROD_W'(1);
      gquo_nxt.step[c] = q_sum[PROD_W-1:CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_GQUO]) begin
      gquo_r <= gquo_nxt;
    end
  end

  // Output stage: apply the gradient steps toward the bottom colour.
  logic [CHAN_W-1:0]          g_top;
  logic [NUM_CHAN*CHAN_W-1:0] grad_rgb;
  logic [PIX_W-1:0]           pix_nxt;
  logic [PIX_W-1:0]           out_pix_r;
  logic                       out_wr_r;

  always_comb begin
    g_top = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      g_top = first_colour_r[c*CHAN_W +: CHAN_W];
      grad_rgb[c*CHAN_W +: CHAN_W] = gquo_r.neg[c] ? (g_top - gquo_r.step[c])
                                                   : (g_top + gquo_r.step[c]);
    end
    pix_nxt = gquo_r.grad_sel ? {ALPHA_OPAQUE, grad_rgb} : gquo_r.base;
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_OUT]) begin
      out_pix_r <= pix_nxt;
      out_wr_r  <= gquo_r.wr;
    end
  end

  assign out_pixel_out  = out_pix_r;
  assign out_write_flag = out_wr_r;

`ifndef SYNTH
  // The input side stalls only when every stage is full and the result is held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&valid_r) && !out_ready)
    else $error("input stalled while the pipeline had room");

  // Reset empties the pipeline and opens the input side.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");
`endif

endmodule
